// ----- rtl/srss_pkg.sv -----
// ----------------------------------------------------------------------------
// srss_pkg: shared types and helpers of the ripple shell shader
// item and result structs, pipeline side-band structs, fixed-point constants
// and the single-step square root and division helpers
// ----------------------------------------------------------------------------
package srss_pkg;

    localparam int COORD_W   = 8;
    localparam int BYTE_W    = 8;
    localparam int ELAPSED_W = 16;
    localparam int GROWTH_W  = 6;
    localparam int HALF_W    = 7;
    localparam int P_W       = ELAPSED_W + GROWTH_W;
    localparam int RAD_W     = 9;
    localparam int D2_W      = 18;
    localparam int ROOT_W    = D2_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int NUM_W     = 15;
    localparam int QUO_W     = 8;

    localparam logic [GROWTH_W-1:0] GROWTH_BASE = GROWTH_W'(3);
    localparam logic [HALF_W-1:0]   HALF_BASE   = HALF_W'(12);
    localparam logic [BYTE_W-1:0]   FULL_SCALE  = 8'd255;

    // radius > 500 exactly when elapsed*growth >= 5762 (2*p/23 > 500)
    localparam logic [P_W-1:0] EXPIRE_P   = P_W'(5762);
    localparam int             P_LIVE_W   = 13;
    // floor(2*p/23) = (p * 2 * ceil(2^18/23)) >> 18, exact for p < 5762
    localparam int             RAD_SHIFT  = 18;
    localparam int             RAD_RCP_W  = 15;
    localparam logic [RAD_RCP_W-1:0] RAD_RCP = RAD_RCP_W'(22796);
    localparam int             RAD_PROD_W = P_LIVE_W + RAD_RCP_W;
    // floor(rad*255/500) = (rad * 51 * ceil(2^20/100)) >> 20, exact for rad <= 500
    localparam int             LIFE_SHIFT  = 20;
    localparam int             LIFE_RCP_W  = 20;
    localparam logic [LIFE_RCP_W-1:0] LIFE_RCP = LIFE_RCP_W'(534786);
    localparam int             LIFE_PROD_W = RAD_W + LIFE_RCP_W;

    localparam int SQRT_STAGES    = 3;
    localparam int SQRT_PER_STAGE = ROOT_W / SQRT_STAGES;
    localparam int DIV_STAGES     = 4;
    localparam int DIV_PER_STAGE  = QUO_W / DIV_STAGES;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH_SPEED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THICKNESS    = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] GROWTH_SPEED_RST = 8'd110;
    localparam logic [BYTE_W-1:0] THICKNESS_RST    = 8'd90;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic signed [COORD_W-1:0] pixel_z;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [ELAPSED_W-1:0]      elapsed_ms;
        logic [BYTE_W-1:0]         base_hue;
        logic [BYTE_W-1:0]         drive_level;
    } pix_t;

    typedef struct packed {
        logic              in_shell;
        logic              expired;
        logic [BYTE_W-1:0] brightness;
        logic [BYTE_W-1:0] palette_index;
    } res_t;

    // values that ride alongside the root and divide work
    typedef struct packed {
        logic              shell;
        logic              expired;
        logic [RAD_W-1:0]  rad;
        logic [BYTE_W-1:0] life;
        logic [BYTE_W-1:0] hue;
        logic [BYTE_W-1:0] drive;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [D2_W-1:0]   rest;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sq_t;

    typedef struct packed {
        side_t             side;
        logic [NUM_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
    } dv_t;

    // one digit of the floor square root, radicand bits consumed from the top
    function automatic sq_t sqrt_step(input sq_t cur);
        sq_t              nxt;
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        nxt   = cur;
        acc   = {cur.rem, cur.rest[D2_W-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        if (acc >= trial)
        begin
            nxt.rem  = REM_W'(acc - trial);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = REM_W'(acc);
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        nxt.rest = {cur.rest[D2_W-3:0], 2'b00};
        return nxt;
    endfunction

    // one quotient bit, msb first, numerator shifted left after each step
    function automatic dv_t div_step(input dv_t cur, input logic [HALF_W-1:0] half);
        dv_t              nxt;
        logic [NUM_W-1:0] dvs;
        logic [NUM_W-1:0] rem;
        logic             qbit;
        nxt = cur;
        dvs = NUM_W'({half, {(QUO_W-1){1'b0}}});
        if (cur.num >= dvs)
        begin
            rem  = cur.num - dvs;
            qbit = 1'b1;
        end
        else
        begin
            rem  = cur.num;
            qbit = 1'b0;
        end
        nxt.num = {rem[NUM_W-2:0], 1'b0};
        nxt.quo = {cur.quo[QUO_W-2:0], qbit};
        return nxt;
    endfunction

endpackage

// ----- rtl/spherical_ripple_shell_shader.sv -----
// ----------------------------------------------------------------------------
// spherical_ripple_shell_shader: ripple shell test and brightness per pixel
// takes one pixel and ripple source pair per transfer and returns shell
// membership, expiry, brightness and palette index
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   --------  ----------------------  -------------------------------------
//   pix       pix_valid / pix_stall   pix_data : pixel, source, time, hue
//   res       res_valid / res_stall   res_data : shell, expired, brightness, palette
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data : register write
//
// one transfer per clock sustained while res_stall is low
// the twelve register stages: three geometry, three root, four divide, two shade
// reset empties every stage and loads the register defaults; no clearing pass
// a res stall holds the output; bubbles still close up behind it, and
// pix_stall rises only when every stage is full
//
module spherical_ripple_shell_shader (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  srss_pkg::pix_t                   pix_data,
    output logic                             res_valid,
    input  logic                             res_stall,
    output srss_pkg::res_t                   res_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srss_pkg::BYTE_W-1:0]      cfg_data
);
    import srss_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0]   growth_speed_reg, growth_speed_next;
    logic [BYTE_W-1:0]   thickness_reg, thickness_next;
    logic [GROWTH_W-1:0] growth;
    logic [HALF_W-1:0]   half;

    // pipeline links
    logic sq_valid [SQRT_STAGES+1];
    logic sq_ready [SQRT_STAGES+1];
    sq_t  sq_data  [SQRT_STAGES+1];
    logic dv_valid [DIV_STAGES+1];
    logic dv_ready [DIV_STAGES+1];
    dv_t  dv_data  [DIV_STAGES+1];
    logic geom_ready;
    logic shade_ready;

    // distance from the shell centre line
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic [RAD_W-1:0]  off_full;
    logic [HALF_W-1:0] off;

    // register writes are always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_comb
    begin
        growth_speed_next = growth_speed_reg;
        thickness_next    = thickness_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GROWTH_SPEED: growth_speed_next = cfg_data;
                REG_THICKNESS:    thickness_next    = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            growth_speed_reg <= GROWTH_SPEED_RST;
            thickness_reg    <= THICKNESS_RST;
        end
        else
        begin
            growth_speed_reg <= growth_speed_next;
            thickness_reg    <= thickness_next;
        end
    end

    // growth factor (radius gain per 23 ms is twice it) and shell half width
    assign growth = GROWTH_BASE + GROWTH_W'(growth_speed_reg[BYTE_W-1:3]);
    assign half   = HALF_BASE + HALF_W'(thickness_reg[BYTE_W-1:2]);

    // geometry: deltas, radius, squared distance, shell test, life
    srss_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .growth    (growth),
        .half      (half),
        .in_valid  (pix_valid),
        .in_data   (pix_data),
        .up_ready  (geom_ready),
        .out_valid (sq_valid[0]),
        .out_data  (sq_data[0]),
        .dn_ready  (sq_ready[0])
    );

    assign pix_stall = !geom_ready;

    // floor square root of the squared distance
    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        srss_sqrt_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_data   (sq_data[k]),
            .up_ready  (sq_ready[k]),
            .out_valid (sq_valid[k+1]),
            .out_data  (sq_data[k+1]),
            .dn_ready  (sq_ready[k+1])
        );
    end

    // offset from the radius; within the shell it never exceeds the half width
    always_comb
    begin
        root     = sq_data[SQRT_STAGES].root;
        rad      = sq_data[SQRT_STAGES].side.rad;
        off_full = (RAD_W'(root) > rad) ? RAD_W'(root) - rad : rad - RAD_W'(root);
        off      = off_full[HALF_W-1:0];

        dv_data[0].side = sq_data[SQRT_STAGES].side;
        // off * 255 as a shift and subtract
        dv_data[0].num  = NUM_W'({off, {BYTE_W{1'b0}}}) - NUM_W'(off);
        dv_data[0].quo  = '0;
    end

    assign dv_valid[0]           = sq_valid[SQRT_STAGES];
    assign sq_ready[SQRT_STAGES] = dv_ready[0];

    // falloff quotient off * 255 / half
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        srss_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .half      (half),
            .in_valid  (dv_valid[k]),
            .in_data   (dv_data[k]),
            .up_ready  (dv_ready[k]),
            .out_valid (dv_valid[k+1]),
            .out_data  (dv_data[k+1]),
            .dn_ready  (dv_ready[k+1])
        );
    end

    assign dv_ready[DIV_STAGES] = shade_ready;

    // brightness scaling and the output register
    srss_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid[DIV_STAGES]),
        .in_data   (dv_data[DIV_STAGES]),
        .up_ready  (shade_ready),
        .out_valid (res_valid),
        .out_data  (res_data),
        .dn_ready  (!res_stall)
    );

    // input is held off only while a valid result is stalled at the output
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (res_valid && res_stall))
        else $error("pix stalled while the result side can move");

    // an expired source never lights a pixel
    a_expired_not_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.expired) |-> !res_data.in_shell)
        else $error("expired source reported inside its shell");

    // a pixel outside the shell is dark
    a_outside_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.in_shell) |-> (res_data.brightness == '0))
        else $error("brightness outside the shell");

endmodule

// ----- rtl/srss_geom.sv -----
// ----------------------------------------------------------------------------
// srss_geom: geometry front end
// three stages: deltas and time product, radius, expiry and squared distance,
// shell bounds test and life factor
// ----------------------------------------------------------------------------
module srss_geom (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [srss_pkg::GROWTH_W-1:0]  growth,
    input  logic [srss_pkg::HALF_W-1:0]    half,
    input  logic                           in_valid,
    input  srss_pkg::pix_t                 in_data,
    output logic                           up_ready,
    output logic                           out_valid,
    output srss_pkg::sq_t                  out_data,
    input  logic                           dn_ready
);
    import srss_pkg::*;

    logic rdy1, rdy2, rdy3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1
    logic signed [COORD_W:0] dx, dy, dz;
    logic [COORD_W:0]        ax9, ay9, az9;
    logic [COORD_W-1:0]      ax_next, ay_next, az_next;
    logic [COORD_W-1:0]      ax_reg, ay_reg, az_reg;
    logic [P_W-1:0]          p_next, p_reg;
    logic [BYTE_W-1:0]       hue1_reg, drive1_reg;

    // stage 2
    logic [RAD_PROD_W-1:0]   rad_prod;
    logic                    exp_next, exp_reg;
    logic [RAD_W-1:0]        rad_next, rad_reg;
    logic [D2_W-1:0]         d2_next, d2_reg;
    logic [BYTE_W-1:0]       hue2_reg, drive2_reg;

    // stage 3
    logic [RAD_W-1:0]        lo;
    logic [RAD_W:0]          hi;
    logic [D2_W-1:0]         lo_sq;
    logic [D2_W+1:0]         hi_sq;
    logic [LIFE_PROD_W-1:0]  life_prod;
    sq_t                     sq_next, sq_reg;

    assign rdy3     = !v3_reg || dn_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;

    always_comb
    begin
        dx  = {in_data.pixel_x[COORD_W-1], in_data.pixel_x}
            - {in_data.origin_x[COORD_W-1], in_data.origin_x};
        dy  = {in_data.pixel_y[COORD_W-1], in_data.pixel_y}
            - {in_data.origin_y[COORD_W-1], in_data.origin_y};
        dz  = {in_data.pixel_z[COORD_W-1], in_data.pixel_z}
            - {in_data.origin_z[COORD_W-1], in_data.origin_z};
        ax9 = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
        ay9 = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
        az9 = dz[COORD_W] ? (COORD_W+1)'(-dz) : (COORD_W+1)'(dz);
        ax_next = ax9[COORD_W-1:0];
        ay_next = ay9[COORD_W-1:0];
        az_next = az9[COORD_W-1:0];
        p_next  = P_W'(in_data.elapsed_ms) * P_W'(growth);
    end

    always_comb
    begin
        exp_next = (p_reg >= EXPIRE_P);
        rad_prod = RAD_PROD_W'(p_reg[P_LIVE_W-1:0]) * RAD_PROD_W'(RAD_RCP);
        rad_next = rad_prod[RAD_SHIFT +: RAD_W];
        d2_next  = D2_W'(ax_reg) * D2_W'(ax_reg) + D2_W'(ay_reg) * D2_W'(ay_reg)
                 + D2_W'(az_reg) * D2_W'(az_reg);
    end

    always_comb
    begin
        lo        = (rad_reg > RAD_W'(half)) ? rad_reg - RAD_W'(half) : '0;
        hi        = (RAD_W+1)'(rad_reg) + (RAD_W+1)'(half);
        lo_sq     = D2_W'(lo) * D2_W'(lo);
        hi_sq     = (D2_W+2)'(hi) * (D2_W+2)'(hi);
        life_prod = LIFE_PROD_W'(rad_reg) * LIFE_PROD_W'(LIFE_RCP);

        sq_next              = '0;
        sq_next.side.shell   = !exp_reg && (d2_reg >= lo_sq)
                             && ((D2_W+2)'(d2_reg) <= hi_sq);
        sq_next.side.expired = exp_reg;
        sq_next.side.rad     = rad_reg;
        sq_next.side.life    = BYTE_W'(RAD_W'(FULL_SCALE) - life_prod[LIFE_SHIFT +: RAD_W]);
        sq_next.side.hue     = hue2_reg;
        sq_next.side.drive   = drive2_reg;
        sq_next.rest         = d2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            az_reg     <= az_next;
            p_reg      <= p_next;
            hue1_reg   <= in_data.base_hue;
            drive1_reg <= in_data.drive_level;
        end
        if (rdy2)
        begin
            exp_reg    <= exp_next;
            rad_reg    <= rad_next;
            d2_reg     <= d2_next;
            hue2_reg   <= hue1_reg;
            drive2_reg <= drive1_reg;
        end
        if (rdy3)
        begin
            sq_reg <= sq_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = sq_reg;

endmodule

// ----- rtl/srss_sqrt_stage.sv -----
// ----------------------------------------------------------------------------
// srss_sqrt_stage: one register stage of the floor square root
// retires a fixed number of root digits per stage
// ----------------------------------------------------------------------------
module srss_sqrt_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  srss_pkg::sq_t in_data,
    output logic          up_ready,
    output logic          out_valid,
    output srss_pkg::sq_t out_data,
    input  logic          dn_ready
);
    import srss_pkg::*;

    logic valid_reg;
    sq_t  work_next;
    sq_t  work_reg;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        work_next = in_data;
        for (int i = 0; i < SQRT_PER_STAGE; i++)
        begin
            work_next = sqrt_step(work_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = work_reg;

endmodule

// ----- rtl/srss_div_stage.sv -----
// ----------------------------------------------------------------------------
// srss_div_stage: one register stage of the falloff divider
// restoring division by the shell half width, a few quotient bits per stage
// ----------------------------------------------------------------------------
module srss_div_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [srss_pkg::HALF_W-1:0] half,
    input  logic                        in_valid,
    input  srss_pkg::dv_t               in_data,
    output logic                        up_ready,
    output logic                        out_valid,
    output srss_pkg::dv_t               out_data,
    input  logic                        dn_ready
);
    import srss_pkg::*;

    logic valid_reg;
    dv_t  work_next;
    dv_t  work_reg;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        work_next = in_data;
        for (int i = 0; i < DIV_PER_STAGE; i++)
        begin
            work_next = div_step(work_next, half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            work_reg <= work_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = work_reg;

endmodule

// ----- rtl/srss_shade.sv -----
// ----------------------------------------------------------------------------
// srss_shade: brightness back end
// two stages: luminance times life, then times drive level into the output
// register with shell gating and palette index
// ----------------------------------------------------------------------------
module srss_shade (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  srss_pkg::dv_t  in_data,
    output logic           up_ready,
    output logic           out_valid,
    output srss_pkg::res_t out_data,
    input  logic           dn_ready
);
    import srss_pkg::*;

    logic                rdy1, rdy2;
    logic                v1_reg, v2_reg;

    logic [BYTE_W-1:0]   lum;
    logic [2*BYTE_W-1:0] b1_prod;
    logic [BYTE_W-1:0]   b1_next, b1_reg;
    logic                shell_reg, exp_reg;
    logic [BYTE_W-1:0]   hue_reg, drive_reg;

    logic [2*BYTE_W-1:0] b2_prod;
    logic [BYTE_W-1:0]   bright;
    res_t                res_next, res_reg;

    assign rdy2     = !v2_reg || dn_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign up_ready = rdy1;

    always_comb
    begin
        lum     = FULL_SCALE - in_data.quo;
        b1_prod = (2*BYTE_W)'(lum) * (2*BYTE_W)'(in_data.side.life);
        b1_next = b1_prod[2*BYTE_W-1:BYTE_W];
    end

    always_comb
    begin
        b2_prod                = (2*BYTE_W)'(b1_reg) * (2*BYTE_W)'(drive_reg);
        bright                 = shell_reg ? b2_prod[2*BYTE_W-1:BYTE_W] : '0;
        res_next.in_shell      = shell_reg;
        res_next.expired       = exp_reg;
        res_next.brightness    = bright;
        res_next.palette_index = hue_reg + BYTE_W'(bright[BYTE_W-1:2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            b1_reg    <= b1_next;
            shell_reg <= in_data.side.shell;
            exp_reg   <= in_data.side.expired;
            hue_reg   <= in_data.side.hue;
            drive_reg <= in_data.side.drive;
        end
        if (rdy2)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = res_reg;

endmodule
